// ===== design/crc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_pkg
// Shared types, constants and helper functions of the cylindrical /
// rectangular point converter.
// ----------------------------------------------------------------------------
package crc_pkg;

    localparam int ROOT_BITS         = 32;
    localparam int ATAN_ENTRIES      = 40;
    localparam int VEC_WIDTH         = 51;
    localparam int VEC_PRESCALE_BITS = 16;

    localparam logic [63:0] GAIN_Q32 = 64'd2608131496;

    localparam logic [31:0] HALF_TURN   = 32'h8000_0000;
    localparam logic [31:0] EIGHTH_TURN = 32'h2000_0000;

    localparam logic signed [31:0] SAT_POS = 32'sh7fff_ffff;
    localparam logic signed [31:0] SAT_NEG = 32'sh8000_0000;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    localparam logic [31:0] ATAN_TABLE [ATAN_ENTRIES] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
        32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
        32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
        32'd20, 32'd10, 32'd5, 32'd3, 32'd1,
        32'd1, 32'd0, 32'd0, 32'd0, 32'd0,
        32'd0, 32'd0, 32'd0, 32'd0, 32'd0
    };

    typedef enum logic {
        DIR_FORWARD = 1'b0,
        DIR_INVERSE = 1'b1
    } crc_dir_t;

    // raw input item
    typedef struct packed {
        crc_dir_t           dir;
        logic signed [31:0] first;
        logic signed [31:0] second;
        logic signed [31:0] third;
    } crc_item_t;

    // cylindrical point used for the rotation and the Jacobian
    typedef struct packed {
        crc_dir_t           dir;
        logic signed [31:0] radius;
        logic [31:0]        angle;
        logic signed [31:0] height;
    } crc_pt_t;

    typedef struct packed {
        logic signed [31:0] out_first;
        logic signed [31:0] out_second;
        logic signed [31:0] out_third;
        logic signed [31:0] jac_rr;
        logic signed [31:0] jac_rt;
        logic signed [31:0] jac_tr;
        logic signed [31:0] jac_tt;
    } crc_res_t;

    function automatic logic [31:0] atan_step(input int i);
        logic [31:0] v;
        begin
            v = 32'd0;
            if (i < ATAN_ENTRIES)
                v = ATAN_TABLE[i];
            return v;
        end
    endfunction

    // CORDIC gain with f fraction bits, rounded half up
    function automatic logic [63:0] cordic_gain(input int f);
        logic [63:0] g;
        begin
            if (f <= 32)
                g = (GAIN_Q32 + ((64'd1 << (32 - f)) >> 1)) >> (32 - f);
            else
                g = GAIN_Q32 << (f - 32);
            return g;
        end
    endfunction

    // Q16.16 x Q2.30 product back to Q16.16, half up, saturated
    function automatic logic signed [31:0] round_q30(input logic signed [63:0] p);
        logic signed [63:0] t;
        logic signed [31:0] r;
        begin
            t = (p + 64'sd536870912) >>> 30;
            if (t > 64'sd2147483647)
                r = SAT_POS;
            else if (t < -64'sd2147483648)
                r = SAT_NEG;
            else
                r = t[31:0];
            return r;
        end
    endfunction

endpackage

// ===== design/cylindrical_rectangular_convert_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cylindrical_rectangular_convert_core
// Cylindrical <-> rectangular point conversion with Jacobian entries,
// CORDIC based, fully pipelined.
// ----------------------------------------------------------------------------
//  channel  signals                                   dir  note
//  in       in_valid, in_stall, in_first..in_third    in   one point per item
//  out      out_valid, out_stall, out_first..jac_tt   out  one result per item
//  cfg      cfg_valid, cfg_ready, cfg_direction       in   direction register
//
//  One item per cycle sustained while no finished item waits behind a stalled output.
//  The front has FRONT = max(32, ROTATION_STAGES) steps: the 32 square root steps and the
//  vectoring stages run side by side, then the rotation stages follow.
//  Reset clears the valid bits and sets direction to forward.
//  The whole pipe holds while a finished item waits behind a full, stalled
//  output register; otherwise bubbles keep moving.
// ----------------------------------------------------------------------------
module cylindrical_rectangular_convert_core
    import crc_pkg::*;
#(
    parameter int COORD_WIDTH     = 32,
    parameter int ROTATION_STAGES = 24
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] in_first,
    input  logic signed [31:0] in_second,
    input  logic signed [31:0] in_third,

    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] out_first,
    output logic signed [31:0] out_second,
    output logic signed [31:0] out_third,
    output logic signed [31:0] jac_rr,
    output logic signed [31:0] jac_rt,
    output logic signed [31:0] jac_tr,
    output logic signed [31:0] jac_tt,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_direction
);

    crc_dir_t  dir_reg;
    logic      adv;
    crc_item_t in_item;

    logic               front_valid;
    crc_pt_t            front_pt;
    logic               rot_valid;
    crc_pt_t            rot_pt;
    logic signed [31:0] rot_cos;
    logic signed [31:0] rot_sin;
    logic               scale_valid;
    crc_dir_t           scale_dir;
    crc_res_t           scale_res;

    logic     out_valid_reg;
    crc_dir_t out_dir_reg;
    crc_res_t out_res_reg;

    assign cfg_ready = 1'b1;

    // pipe moves unless a finished item would hit a full, stalled output
    assign adv      = !out_valid_reg || !out_stall || !scale_valid;
    assign in_stall = !adv;

    assign in_item.dir    = dir_reg;
    assign in_item.first  = in_first;
    assign in_item.second = in_second;
    assign in_item.third  = in_third;

    crc_front #(
        .ROT_STAGES (ROTATION_STAGES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (in_valid),
        .in_item   (in_item),
        .out_valid (front_valid),
        .out_pt    (front_pt)
    );

    crc_rotate #(
        .COORD_WIDTH (COORD_WIDTH),
        .ROT_STAGES  (ROTATION_STAGES)
    ) u_rotate (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (front_valid),
        .in_pt     (front_pt),
        .out_valid (rot_valid),
        .out_pt    (rot_pt),
        .out_cos   (rot_cos),
        .out_sin   (rot_sin)
    );

    crc_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (rot_valid),
        .in_pt     (rot_pt),
        .in_cos    (rot_cos),
        .in_sin    (rot_sin),
        .out_valid (scale_valid),
        .out_dir   (scale_dir),
        .out_res   (scale_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg       <= DIR_FORWARD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                dir_reg <= crc_dir_t'(cfg_direction);
            if (!out_valid_reg || !out_stall)
                out_valid_reg <= scale_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !out_stall)
        begin
            out_dir_reg <= scale_dir;
            out_res_reg <= scale_res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_first  = out_res_reg.out_first;
    assign out_second = out_res_reg.out_second;
    assign out_third  = out_res_reg.out_third;
    assign jac_rr     = out_res_reg.jac_rr;
    assign jac_rt     = out_res_reg.jac_rt;
    assign jac_tr     = out_res_reg.jac_tr;
    assign jac_tt     = out_res_reg.jac_tt;

`ifndef SYNTHESIS
    // a finished item waiting behind a stalled output holds the input
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall && scale_valid) |-> in_stall)
        else $error("input not held behind a full stalled output");

    // inverse radius is never negative
    a_radius_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_dir_reg == DIR_INVERSE)) |-> !out_first[31])
        else $error("negative radius in inverse result");

    // cosine and sine entries stay within one in Q16.16
    a_jac_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (jac_rr <= 32'sd65536) && (jac_rr >= -32'sd65536) &&
                          (jac_tr <= 32'sd65536) && (jac_tr >= -32'sd65536))
        else $error("trig Jacobian entry out of range");
`endif

endmodule

// ===== design/crc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_front
// Input register, squares, bit-per-stage square root and vectoring CORDIC
// for the inverse direction; forward items ride along unchanged.
// ----------------------------------------------------------------------------
module crc_front
    import crc_pkg::*;
#(
    parameter int ROT_STAGES = 24
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      adv,
    input  logic      in_valid,
    input  crc_item_t in_item,
    output logic      out_valid,
    output crc_pt_t   out_pt
);

    localparam int FRONT = (ROT_STAGES > ROOT_BITS) ? ROT_STAGES : ROOT_BITS;

    // input register
    logic      p1_valid_reg;
    crc_item_t p1_item_reg;

    // squares and vector start
    logic                        p2_valid_reg;
    crc_item_t                   p2_item_reg;
    logic [63:0]                 p2_sqx_reg;
    logic [63:0]                 p2_sqy_reg;
    logic signed [VEC_WIDTH-1:0] p2_vx_reg;
    logic signed [VEC_WIDTH-1:0] p2_vy_reg;
    logic [31:0]                 p2_vz_reg;
    logic                        p2_zero_reg;

    logic [31:0]                 ax;
    logic [31:0]                 ay;
    logic                        neg_x;
    logic signed [VEC_WIDTH-1:0] xs;
    logic signed [VEC_WIDTH-1:0] ys;

    assign neg_x = p1_item_reg.first[31];
    assign ax    = neg_x ? 32'(-p1_item_reg.first) : 32'(p1_item_reg.first);
    assign ay    = p1_item_reg.second[31] ? 32'(-p1_item_reg.second)
                                          : 32'(p1_item_reg.second);
    assign xs    = VEC_WIDTH'(p1_item_reg.first);
    assign ys    = VEC_WIDTH'(p1_item_reg.second);

    // stage chain: index 0 is the start, index k+1 follows step k
    logic                        valid_reg [0:FRONT];
    crc_item_t                   item_reg  [0:FRONT];
    logic                        zero_reg  [0:FRONT];
    logic [63:0]                 rem_reg   [0:FRONT];
    logic [31:0]                 q_reg     [0:FRONT];
    logic signed [VEC_WIDTH-1:0] vx_reg    [0:FRONT];
    logic signed [VEC_WIDTH-1:0] vy_reg    [0:FRONT];
    logic [31:0]                 vz_reg    [0:FRONT];

    logic [63:0]                 rem_next  [1:FRONT];
    logic [31:0]                 q_next    [1:FRONT];
    logic signed [VEC_WIDTH-1:0] vx_next   [1:FRONT];
    logic signed [VEC_WIDTH-1:0] vy_next   [1:FRONT];
    logic [31:0]                 vz_next   [1:FRONT];

    for (genvar k = 0; k < FRONT; k++) begin : g_step
        localparam int          B  = (k < ROOT_BITS) ? (ROOT_BITS - 1 - k) : 0;
        localparam logic [31:0] AT = atan_step(k);

        logic [63:0] trial;
        logic        take;
        logic        y_pos;

        assign trial = ({32'b0, q_reg[k]} << (B + 1)) | (64'd1 << (2 * B));
        assign take  = (k < ROOT_BITS) && (rem_reg[k] >= trial);
        assign rem_next[k+1] = take ? (rem_reg[k] - trial) : rem_reg[k];
        assign q_next[k+1]   = take ? (q_reg[k] | (32'd1 << B)) : q_reg[k];

        // rotate toward y = 0, accumulating the angle
        assign y_pos = !vy_reg[k][VEC_WIDTH-1];
        assign vx_next[k+1] = (k >= ROT_STAGES) ? vx_reg[k] :
                              y_pos ? (vx_reg[k] + (vy_reg[k] >>> k))
                                    : (vx_reg[k] - (vy_reg[k] >>> k));
        assign vy_next[k+1] = (k >= ROT_STAGES) ? vy_reg[k] :
                              y_pos ? (vy_reg[k] - (vx_reg[k] >>> k))
                                    : (vy_reg[k] + (vx_reg[k] >>> k));
        assign vz_next[k+1] = (k >= ROT_STAGES) ? vz_reg[k] :
                              y_pos ? (vz_reg[k] + AT) : (vz_reg[k] - AT);
    end

    // finish: round the root, pick the cylindrical point
    logic              fin_valid_reg;
    crc_pt_t           fin_pt_reg;
    logic [32:0]       root;
    logic signed [31:0] root_sat;
    crc_pt_t           fin_pt_next;

    assign root     = {1'b0, q_reg[FRONT]} +
                      33'((rem_reg[FRONT] > {32'b0, q_reg[FRONT]}) ? 1 : 0);
    assign root_sat = (root > 33'h0_7fff_ffff) ? SAT_POS : root[31:0];

    always_comb
    begin
        fin_pt_next.dir    = item_reg[FRONT].dir;
        fin_pt_next.height = item_reg[FRONT].third;
        if (item_reg[FRONT].dir == DIR_INVERSE)
        begin
            fin_pt_next.radius = root_sat;
            fin_pt_next.angle  = zero_reg[FRONT] ? 32'd0 : vz_reg[FRONT];
        end
        else
        begin
            fin_pt_next.radius = item_reg[FRONT].first;
            fin_pt_next.angle  = item_reg[FRONT].second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            fin_valid_reg <= 1'b0;
            for (int i = 0; i <= FRONT; i++)
                valid_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            p1_valid_reg  <= in_valid;
            p2_valid_reg  <= p1_valid_reg;
            valid_reg[0]  <= p2_valid_reg;
            for (int i = 1; i <= FRONT; i++)
                valid_reg[i] <= valid_reg[i-1];
            fin_valid_reg <= valid_reg[FRONT];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_item_reg <= in_item;

            p2_item_reg <= p1_item_reg;
            p2_sqx_reg  <= {32'b0, ax} * {32'b0, ax};
            p2_sqy_reg  <= {32'b0, ay} * {32'b0, ay};
            p2_vx_reg   <= (neg_x ? -xs : xs) <<< VEC_PRESCALE_BITS;
            p2_vy_reg   <= (neg_x ? -ys : ys) <<< VEC_PRESCALE_BITS;
            p2_vz_reg   <= neg_x ? HALF_TURN : 32'd0;
            p2_zero_reg <= (p1_item_reg.first == 32'sd0) && (p1_item_reg.second == 32'sd0);

            item_reg[0] <= p2_item_reg;
            zero_reg[0] <= p2_zero_reg;
            rem_reg[0]  <= p2_sqx_reg + p2_sqy_reg;
            q_reg[0]    <= 32'd0;
            vx_reg[0]   <= p2_vx_reg;
            vy_reg[0]   <= p2_vy_reg;
            vz_reg[0]   <= p2_vz_reg;
            for (int i = 1; i <= FRONT; i++)
            begin
                item_reg[i] <= item_reg[i-1];
                zero_reg[i] <= zero_reg[i-1];
                rem_reg[i]  <= rem_next[i];
                q_reg[i]    <= q_next[i];
                vx_reg[i]   <= vx_next[i];
                vy_reg[i]   <= vy_next[i];
                vz_reg[i]   <= vz_next[i];
            end

            fin_pt_reg <= fin_pt_next;
        end
    end

    assign out_valid = fin_valid_reg;
    assign out_pt    = fin_pt_reg;

endmodule

// ===== design/crc_rotate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_rotate
// Rotation CORDIC: cosine and sine of the point's angle in Q2.30.
// ----------------------------------------------------------------------------
module crc_rotate
    import crc_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int ROT_STAGES  = 24
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_valid,
    input  crc_pt_t            in_pt,
    output logic               out_valid,
    output crc_pt_t            out_pt,
    output logic signed [31:0] out_cos,
    output logic signed [31:0] out_sin
);

    localparam int F    = COORD_WIDTH - 2;
    localparam int SH_R = (F > 30) ? (F - 30) : 0;
    localparam int SH_L = (F > 30) ? 0 : (30 - F);
    localparam logic signed [63:0] RND = (F > 30) ? (64'sd1 <<< (F - 31)) : 64'sd0;
    localparam logic signed [COORD_WIDTH-1:0] K = COORD_WIDTH'(cordic_gain(F));
    localparam logic signed [63:0] ONE_Q30 = 64'sd1073741824;

    logic                          valid_reg [0:ROT_STAGES];
    crc_pt_t                       pt_reg    [0:ROT_STAGES];
    logic [1:0]                    quad_reg  [0:ROT_STAGES];
    logic signed [COORD_WIDTH-1:0] x_reg     [0:ROT_STAGES];
    logic signed [COORD_WIDTH-1:0] y_reg     [0:ROT_STAGES];
    logic signed [33:0]            z_reg     [0:ROT_STAGES];

    logic signed [COORD_WIDTH-1:0] x_next [1:ROT_STAGES];
    logic signed [COORD_WIDTH-1:0] y_next [1:ROT_STAGES];
    logic signed [33:0]            z_next [1:ROT_STAGES];

    // quadrant split: residual lies in [-1/8, 1/8) turn
    logic [1:0]  quad;
    logic [31:0] rest;

    assign quad = 2'((in_pt.angle + EIGHTH_TURN) >> 30);
    assign rest = in_pt.angle - {quad, 30'b0};

    for (genvar k = 0; k < ROT_STAGES; k++) begin : g_step
        localparam logic signed [33:0] AT = 34'(atan_step(k));

        logic z_pos;

        assign z_pos     = !z_reg[k][33];
        assign x_next[k+1] = z_pos ? (x_reg[k] - (y_reg[k] >>> k))
                                   : (x_reg[k] + (y_reg[k] >>> k));
        assign y_next[k+1] = z_pos ? (y_reg[k] + (x_reg[k] >>> k))
                                   : (y_reg[k] - (x_reg[k] >>> k));
        assign z_next[k+1] = z_pos ? (z_reg[k] - AT) : (z_reg[k] + AT);
    end

    // back to Q2.30, clamped to [-1, 1]
    logic signed [63:0] xw;
    logic signed [63:0] yw;
    logic signed [31:0] xq;
    logic signed [31:0] yq;
    logic signed [31:0] cos_next;
    logic signed [31:0] sin_next;

    assign xw = ((64'(x_reg[ROT_STAGES]) + RND) >>> SH_R) <<< SH_L;
    assign yw = ((64'(y_reg[ROT_STAGES]) + RND) >>> SH_R) <<< SH_L;
    assign xq = (xw > ONE_Q30) ? 32'(ONE_Q30) : (xw < -ONE_Q30) ? 32'(-ONE_Q30) : xw[31:0];
    assign yq = (yw > ONE_Q30) ? 32'(ONE_Q30) : (yw < -ONE_Q30) ? 32'(-ONE_Q30) : yw[31:0];

    always_comb
    begin
        case (quad_reg[ROT_STAGES])
            QUAD_0:
            begin
                cos_next = xq;
                sin_next = yq;
            end
            QUAD_1:
            begin
                cos_next = -yq;
                sin_next = xq;
            end
            QUAD_2:
            begin
                cos_next = -xq;
                sin_next = -yq;
            end
            QUAD_3:
            begin
                cos_next = yq;
                sin_next = -xq;
            end
            default:
            begin
                cos_next = xq;
                sin_next = yq;
            end
        endcase
    end

    logic               fin_valid_reg;
    crc_pt_t            fin_pt_reg;
    logic signed [31:0] fin_cos_reg;
    logic signed [31:0] fin_sin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
            for (int i = 0; i <= ROT_STAGES; i++)
                valid_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i <= ROT_STAGES; i++)
                valid_reg[i] <= valid_reg[i-1];
            fin_valid_reg <= valid_reg[ROT_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pt_reg[0]   <= in_pt;
            quad_reg[0] <= quad;
            x_reg[0]    <= K;
            y_reg[0]    <= '0;
            z_reg[0]    <= {{2{rest[31]}}, rest};
            for (int i = 1; i <= ROT_STAGES; i++)
            begin
                pt_reg[i]   <= pt_reg[i-1];
                quad_reg[i] <= quad_reg[i-1];
                x_reg[i]    <= x_next[i];
                y_reg[i]    <= y_next[i];
                z_reg[i]    <= z_next[i];
            end
            fin_pt_reg  <= pt_reg[ROT_STAGES];
            fin_cos_reg <= cos_next;
            fin_sin_reg <= sin_next;
        end
    end

    assign out_valid = fin_valid_reg;
    assign out_pt    = fin_pt_reg;
    assign out_cos   = fin_cos_reg;
    assign out_sin   = fin_sin_reg;

endmodule

// ===== design/crc_scale.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_scale
// Radius products, rounding and saturation; assembles the result item.
// ----------------------------------------------------------------------------
module crc_scale
    import crc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_valid,
    input  crc_pt_t            in_pt,
    input  logic signed [31:0] in_cos,
    input  logic signed [31:0] in_sin,
    output logic               out_valid,
    output crc_dir_t           out_dir,
    output crc_res_t           out_res
);

    logic               m_valid_reg;
    crc_pt_t            m_pt_reg;
    logic signed [31:0] m_cos_reg;
    logic signed [31:0] m_sin_reg;
    logic signed [63:0] m_pc_reg;
    logic signed [63:0] m_ps_reg;

    logic               r_valid_reg;
    crc_dir_t           r_dir_reg;
    crc_res_t           r_res_reg;
    crc_res_t           res_next;

    logic signed [31:0] rc;
    logic signed [31:0] rs;
    logic signed [31:0] cos_rnd;
    logic signed [31:0] sin_rnd;

    assign rc      = round_q30(m_pc_reg);
    assign rs      = round_q30(m_ps_reg);
    assign cos_rnd = (m_cos_reg + 32'sd8192) >>> 14;
    assign sin_rnd = (m_sin_reg + 32'sd8192) >>> 14;

    always_comb
    begin
        res_next.out_third = m_pt_reg.height;
        res_next.jac_rr    = cos_rnd;
        res_next.jac_tr    = sin_rnd;
        res_next.jac_tt    = rc;
        // -r*sin is rounded on its own, not as a negated r*sin
        res_next.jac_rt    = round_q30(-m_ps_reg);
        if (m_pt_reg.dir == DIR_INVERSE)
        begin
            res_next.out_first  = m_pt_reg.radius;
            res_next.out_second = m_pt_reg.angle;
        end
        else
        begin
            res_next.out_first  = rc;
            res_next.out_second = rs;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_valid_reg <= in_valid;
            r_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_pt_reg  <= in_pt;
            m_cos_reg <= in_cos;
            m_sin_reg <= in_sin;
            m_pc_reg  <= 64'(in_pt.radius) * 64'(in_cos);
            m_ps_reg  <= 64'(in_pt.radius) * 64'(in_sin);
            r_dir_reg <= m_pt_reg.dir;
            r_res_reg <= res_next;
        end
    end

    assign out_valid = r_valid_reg;
    assign out_dir   = r_dir_reg;
    assign out_res   = r_res_reg;

endmodule
